>>> sv/bsim_pkg.sv
// ----------------------------------------------------------------------------
// bsim_pkg
// Shared types, constants and the register address decoder for the bank
// switch and scanline IRQ mapper.
// ----------------------------------------------------------------------------
package bsim_pkg;

  localparam int PATTERN_SLOTS_DEF = 8;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int SLOT_FW  = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_BANK_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_IS_ROM = 1'd1;

  localparam logic [7:0] LAST_BANK_MASK_RST = 8'd31;

  // Address pages.
  localparam logic [3:0] PAGE_SWAP   = 4'h8;
  localparam logic [3:0] PAGE_MISC   = 4'h9;
  localparam logic [3:0] PAGE_MIDDLE = 4'hA;
  localparam logic [3:0] PAGE_PAT0   = 4'hB;
  localparam logic [3:0] PAGE_PAT1   = 4'hC;
  localparam logic [3:0] PAGE_PAT2   = 4'hD;
  localparam logic [3:0] PAGE_PAT3   = 4'hE;
  localparam logic [3:0] PAGE_IRQ    = 4'hF;

  // Sub-register codes.
  localparam logic [1:0] SUB_0 = 2'd0;
  localparam logic [1:0] SUB_1 = 2'd1;
  localparam logic [1:0] SUB_2 = 2'd2;
  localparam logic [1:0] SUB_3 = 2'd3;

  localparam logic signed [9:0] PRESCALE_START = 10'sd341;
  localparam logic signed [9:0] PRESCALE_STEP  = 10'sd3;
  localparam logic [7:0]        COUNT_TOP      = 8'hFF;

  typedef struct packed {
    logic       hit;
    logic [3:0] page;
    logic [1:0] sub;
  } dec_t;

  typedef struct packed {
    logic       tick;
    logic       reload_lo;
    logic       reload_hi;
    logic       ctrl;
    logic       ack;
    logic [7:0] value;
  } irq_cmd_t;

  function automatic dec_t decode_addr(input logic [ADDR_W-1:0] addr);
    dec_t d;
    d.page = addr[15:12];
    d.sub  = SUB_0;
    d.hit  = 1'b1;
    case (addr[11:0])
      12'h000: d.sub = SUB_0;
      12'h002, 12'h040: d.sub = SUB_1;
      12'h004, 12'h080: d.sub = SUB_2;
      12'h006, 12'h0C0: d.sub = SUB_3;
      default: d.hit = 1'b0;
    endcase
    if (!addr[15]) begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> sv/bsim_pat_ram.sv
// ----------------------------------------------------------------------------
// bsim_pat_ram
// Pattern bank store: one write port, two registered read ports. Entries
// that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module bsim_pat_ram
  import bsim_pkg::*;
#(
  parameter int PATTERN_SLOTS = PATTERN_SLOTS_DEF,
  parameter int SLOT_W        = $clog2(PATTERN_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [SLOT_W-1:0] raddr_a,
  input  logic [SLOT_W-1:0] raddr_b,
  output logic [7:0]        rdata_a,
  output logic [7:0]        rdata_b
);

  logic [7:0]               mem [PATTERN_SLOTS];
  logic [PATTERN_SLOTS-1:0] vld_r;
  logic [7:0]               rdata_a_r;
  logic [7:0]               rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= vld_r[raddr_a] ? mem[raddr_a] : 8'd0;
      rdata_b_r <= vld_r[raddr_b] ? mem[raddr_b] : 8'd0;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> sv/bsim_irq_unit.sv
// ----------------------------------------------------------------------------
// bsim_irq_unit
// IRQ reload, prescaler, counter and line. Commands arrive already gated
// by the pipeline advance, so the registers load their next value each cycle.
// ----------------------------------------------------------------------------
module bsim_irq_unit
  import bsim_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  irq_cmd_t cmd,
  output logic     asserted_nxt
);

  logic [7:0]        reload_r, reload_nxt;
  logic [7:0]        count_r, count_nxt;
  logic signed [9:0] prescale_r, prescale_nxt;
  logic              cycle_mode_r, cycle_mode_nxt;
  logic              on_r, on_nxt;
  logic              on_after_ack_r, on_after_ack_nxt;
  logic              asserted_r;
  logic [7:0]        count_inc;
  logic              do_step;

  assign count_inc = count_r + 8'd1;

  always_comb begin
    reload_nxt       = reload_r;
    count_nxt        = count_r;
    prescale_nxt     = prescale_r;
    cycle_mode_nxt   = cycle_mode_r;
    on_nxt           = on_r;
    on_after_ack_nxt = on_after_ack_r;
    asserted_nxt     = asserted_r;
    do_step          = 1'b0;

    if (cmd.reload_lo) begin
      reload_nxt = {reload_r[7:4], cmd.value[3:0]};
    end
    if (cmd.reload_hi) begin
      reload_nxt = {cmd.value[3:0], reload_r[3:0]};
    end
    if (cmd.ctrl) begin
      cycle_mode_nxt   = cmd.value[2];
      on_nxt           = cmd.value[1];
      on_after_ack_nxt = cmd.value[0];
      asserted_nxt     = 1'b0;
      if (cmd.value[1]) begin
        count_nxt    = reload_r;
        prescale_nxt = PRESCALE_START;
      end
    end
    if (cmd.ack) begin
      asserted_nxt = 1'b0;
      on_nxt       = on_after_ack_r;
    end

    if (cmd.tick && on_r) begin
      if (cycle_mode_r) begin
        do_step = 1'b1;
      end else if (prescale_r > 10'sd0) begin
        prescale_nxt = prescale_r - PRESCALE_STEP;
      end else begin
        prescale_nxt = prescale_r + PRESCALE_START;
        do_step      = 1'b1;
      end
    end

    // Only a step that lands on the top value raises the line; it also reloads the counter.
    if (do_step) begin
      if (count_inc == COUNT_TOP) begin
        asserted_nxt = 1'b1;
        count_nxt    = reload_r;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r       <= 8'd0;
      count_r        <= 8'd0;
      prescale_r     <= PRESCALE_START;
      cycle_mode_r   <= 1'b0;
      on_r           <= 1'b0;
      on_after_ack_r <= 1'b0;
      asserted_r     <= 1'b0;
    end else begin
      reload_r       <= reload_nxt;
      count_r        <= count_nxt;
      prescale_r     <= prescale_nxt;
      cycle_mode_r   <= cycle_mode_nxt;
      on_r           <= on_nxt;
      on_after_ack_r <= on_after_ack_nxt;
      asserted_r     <= asserted_nxt;
    end
  end

endmodule

>>> sv/bank_switch_and_scanline_irq_mapper.sv
// ----------------------------------------------------------------------------
// bank_switch_and_scanline_irq_mapper
// A request is registered in the compute stage and its result in the output
// register. Throughput: one request per cycle unless the output stalls.
// The pattern RAM is read on accept and written back as the request leaves
// the compute stage, with a one-entry forward for back-to-back same-slot requests.
// Reset (synchronous, active low) resets all mapping and IRQ state.
// ----------------------------------------------------------------------------
module bank_switch_and_scanline_irq_mapper
  import bsim_pkg::*;
#(
  parameter int PATTERN_SLOTS = PATTERN_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: address[15:0], value[23:16], pattern_slot[26:24], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind[0]
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // out_tdata: bank_at_8000[7:0], bank_at_a000[12:8], bank_at_c000[20:13],
  // mirror_mode[22:21], pattern_bank[30:23], pattern_target_rom[31],
  // irq_line[32], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SLOT_W = $clog2(PATTERN_SLOTS);

  // Configuration registers.
  logic [7:0] mask_r;
  logic       is_rom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= LAST_BANK_MASK_RST;
      is_rom_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAST_BANK_MASK: mask_r   <= cfg_wdata;
        CFG_PATTERN_IS_ROM: is_rom_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input decode and pattern write slot.
  dec_t              in_dec;
  logic [3:0]        in_page_off;
  logic [SLOT_W-1:0] in_wslot;
  logic [SLOT_W-1:0] in_rslot;
  logic              in_fire;

  assign in_dec      = decode_addr(in_tdata[15:0]);
  assign in_page_off = in_dec.page - PAGE_PAT0;
  assign in_wslot    = SLOT_W'({in_page_off[1:0], in_dec.sub[1]});
  assign in_rslot    = in_tdata[24 +: SLOT_W];
  assign in_fire     = in_tvalid && in_tready;

  // Compute stage.
  logic              s2_valid_r;
  logic              s2_kind_r;
  dec_t              s2_dec_r;
  logic [7:0]        s2_value_r;
  logic [SLOT_W-1:0] s2_wslot_r;
  logic [SLOT_W-1:0] s2_rslot_r;
  logic              s2_fire;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign s2_fire   = s2_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s2_valid_r || s2_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_fire) begin
      s2_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_kind_r  <= in_tuser;
      s2_dec_r   <= in_dec;
      s2_value_r <= in_tdata[23:16];
      s2_wslot_r <= in_wslot;
      s2_rslot_r <= in_rslot;
    end
  end

  // Pattern RAM with a forward of the most recent write.
  logic              pat_we;
  logic [7:0]        pat_new;
  logic [7:0]        rdata_a, rdata_b;
  logic [7:0]        cur_a, cur_b;
  logic              fwd_valid_r;
  logic [SLOT_W-1:0] fwd_addr_r;
  logic [7:0]        fwd_data_r;

  bsim_pat_ram #(
    .PATTERN_SLOTS (PATTERN_SLOTS),
    .SLOT_W        (SLOT_W)
  ) u_pat_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (pat_we),
    .waddr   (s2_wslot_r),
    .wdata   (pat_new),
    .re      (in_fire),
    .raddr_a (in_wslot),
    .raddr_b (in_rslot),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (pat_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      fwd_addr_r <= s2_wslot_r;
      fwd_data_r <= pat_new;
    end
  end

  // A write retiring on the same edge as a read is missed by the RAM.
  assign cur_a = (fwd_valid_r && fwd_addr_r == s2_wslot_r) ? fwd_data_r : rdata_a;
  assign cur_b = (fwd_valid_r && fwd_addr_r == s2_rslot_r) ? fwd_data_r : rdata_b;

  // Register write decode for the request in the compute stage.
  logic       wr_hit;
  logic [4:0] swap_bank_r, swap_bank_nxt;
  logic       swap_mode_r, swap_mode_nxt;
  logic [4:0] middle_r, middle_nxt;
  logic [1:0] mirror_r, mirror_nxt;
  irq_cmd_t   irq_cmd;
  logic       irq_asserted_nxt;

  assign wr_hit = s2_fire && !s2_kind_r && s2_dec_r.hit;

  always_comb begin
    swap_bank_nxt = swap_bank_r;
    swap_mode_nxt = swap_mode_r;
    middle_nxt    = middle_r;
    mirror_nxt    = mirror_r;
    pat_we        = 1'b0;
    pat_new       = cur_a;
    irq_cmd       = '0;
    irq_cmd.value = s2_value_r;
    irq_cmd.tick  = s2_fire && s2_kind_r;
    if (wr_hit) begin
      case (s2_dec_r.page)
        PAGE_SWAP:   swap_bank_nxt = s2_value_r[4:0];
        PAGE_MISC: begin
          if (!s2_dec_r.sub[1]) begin
            mirror_nxt = s2_value_r[1:0];
          end else begin
            swap_mode_nxt = s2_value_r[1];
          end
        end
        PAGE_MIDDLE: middle_nxt = s2_value_r[4:0];
        PAGE_PAT0, PAGE_PAT1, PAGE_PAT2, PAGE_PAT3: begin
          pat_we = 1'b1;
          if (s2_dec_r.sub[0]) begin
            pat_new = {s2_value_r[3:0], cur_a[3:0]};
          end else begin
            pat_new = {cur_a[7:4], s2_value_r[3:0]};
          end
        end
        PAGE_IRQ: begin
          case (s2_dec_r.sub)
            SUB_0:   irq_cmd.reload_lo = 1'b1;
            SUB_1:   irq_cmd.reload_hi = 1'b1;
            SUB_2:   irq_cmd.ctrl      = 1'b1;
            SUB_3:   irq_cmd.ack       = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_bank_r <= 5'd0;
      swap_mode_r <= 1'b0;
      middle_r    <= 5'd0;
      mirror_r    <= 2'd0;
    end else begin
      swap_bank_r <= swap_bank_nxt;
      swap_mode_r <= swap_mode_nxt;
      middle_r    <= middle_nxt;
      mirror_r    <= mirror_nxt;
    end
  end

  bsim_irq_unit u_irq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (irq_cmd),
    .asserted_nxt (irq_asserted_nxt)
  );

  // Result assembly from the updated state.
  logic [7:0] second_last;
  logic [7:0] bank_8000, bank_c000;
  logic [7:0] rep_bank;

  assign second_last = mask_r - 8'd1;
  assign bank_8000   = swap_mode_nxt ? second_last : {3'd0, swap_bank_nxt};
  assign bank_c000   = swap_mode_nxt ? {3'd0, swap_bank_nxt} : second_last;
  assign rep_bank    = (pat_we && s2_wslot_r == s2_rslot_r) ? pat_new : cur_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_tdata_r <= {7'd0, irq_asserted_nxt, is_rom_r, rep_bank, mirror_nxt,
                      bank_c000, middle_nxt, bank_8000};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule
